>>> rtl/tfb_pkg.sv
`timescale 1ns / 1ps
package tfb_pkg;

    typedef enum logic [1:0] {
        CMD_GLYPH  = 2'd0,
        CMD_NUMBER = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_SCAN   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_DRAW,
        ST_CLEAR,
        ST_READ,
        ST_OUT
    } state_t;

    localparam int unsigned GLYPH_COLS   = 6;
    localparam logic [7:0]  FONT_FIRST   = 8'h20;
    localparam logic [7:0]  FONT_LAST    = 8'h7F;
    localparam logic [7:0]  PAGE_CMD     = 8'hB0;
    localparam logic [7:0]  COL_LOW_CMD  = 8'h00;
    localparam logic [7:0]  COL_HIGH_CMD = 8'h10;
    localparam logic [7:0]  DIGIT_BASE   = 8'd48;
    localparam int unsigned HEADER_SLOTS = 3;

    // Write request from the draw sequencer to the store.
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_data;
    } wr_req_t;

    // Font lookup: six column bytes packed, column 0 in the low byte.
    function automatic logic [47:0] font_row(input logic [6:0] idx);
        logic [47:0] r;
        begin
            case (idx)
                7'd0:  r = 48'h000000000000;
                7'd1:  r = 48'h00005f000000;
                7'd2:  r = 48'h000700070000;
                7'd3:  r = 48'h147f147f1400;
                7'd4:  r = 48'h122a7f2a2400;
                7'd5:  r = 48'h626408132300;
                7'd6:  r = 48'h502255493600;
                7'd7:  r = 48'h000003050000;
                7'd8:  r = 48'h0041221c0000;
                7'd9:  r = 48'h001c22410000;
                7'd10: r = 48'h14083e081400;
                7'd11: r = 48'h08083e080800;
                7'd12: r = 48'h000030500000;
                7'd13: r = 48'h080808080800;
                7'd14: r = 48'h000060600000;
                7'd15: r = 48'h020408102000;
                7'd16: r = 48'h3e4549513e00;
                7'd17: r = 48'h00407f420000;
                7'd18: r = 48'h464951614200;
                7'd19: r = 48'h314b45412100;
                7'd20: r = 48'h107f12141800;
                7'd21: r = 48'h394545452700;
                7'd22: r = 48'h3049494a3c00;
                7'd23: r = 48'h030509710100;
                7'd24: r = 48'h364949493600;
                7'd25: r = 48'h1e2949490600;
                7'd26: r = 48'h000036360000;
                7'd27: r = 48'h000036560000;
                7'd28: r = 48'h004122140800;
                7'd29: r = 48'h141414141400;
                7'd30: r = 48'h081422410000;
                7'd31: r = 48'h060951010200;
                7'd32: r = 48'h3e4179493200;
                7'd33: r = 48'h7e1111117e00;
                7'd34: r = 48'h364949497f00;
                7'd35: r = 48'h224141413e00;
                7'd36: r = 48'h1c2241417f00;
                7'd37: r = 48'h414949497f00;
                7'd38: r = 48'h010909097f00;
                7'd39: r = 48'h7a4949413e00;
                7'd40: r = 48'h7f0808087f00;
                7'd41: r = 48'h00417f410000;
                7'd42: r = 48'h013f41402000;
                7'd43: r = 48'h412214087f00;
                7'd44: r = 48'h404040407f00;
                7'd45: r = 48'h7f020c027f00;
                7'd46: r = 48'h7f1008047f00;
                7'd47: r = 48'h3e4141413e00;
                7'd48: r = 48'h060909097f00;
                7'd49: r = 48'h5e2151413e00;
                7'd50: r = 48'h462919097f00;
                7'd51: r = 48'h314949494600;
                7'd52: r = 48'h01017f010100;
                7'd53: r = 48'h3f4040403f00;
                7'd54: r = 48'h1f2040201f00;
                7'd55: r = 48'h3f4038403f00;
                7'd56: r = 48'h631408146300;
                7'd57: r = 48'h070870080700;
                7'd58: r = 48'h434549516100;
                7'd59: r = 48'h0041417f0000;
                7'd60: r = 48'h201008040200;
                7'd61: r = 48'h007f41410000;
                7'd62: r = 48'h040201020400;
                7'd63: r = 48'h404040404000;
                7'd64: r = 48'h000402010000;
                7'd65: r = 48'h785454542000;
                7'd66: r = 48'h384444487f00;
                7'd67: r = 48'h204444443800;
                7'd68: r = 48'h7f4844443800;
                7'd69: r = 48'h185454543800;
                7'd70: r = 48'h0201097e0800;
                7'd71: r = 48'h3e5252520c00;
                7'd72: r = 48'h780404087f00;
                7'd73: r = 48'h00407d440000;
                7'd74: r = 48'h003d44402000;
                7'd75: r = 48'h004428107f00;
                7'd76: r = 48'h00407f410000;
                7'd77: r = 48'h780418047c00;
                7'd78: r = 48'h780404087c00;
                7'd79: r = 48'h384444443800;
                7'd80: r = 48'h081414147c00;
                7'd81: r = 48'h7c1814140800;
                7'd82: r = 48'h080404087c00;
                7'd83: r = 48'h205454544800;
                7'd84: r = 48'h2040443f0400;
                7'd85: r = 48'h7c2040403c00;
                7'd86: r = 48'h1c2040201c00;
                7'd87: r = 48'h3c4030403c00;
                7'd88: r = 48'h442810284400;
                7'd89: r = 48'h3c5050500c00;
                7'd90: r = 48'h444c54644400;
                7'd91: r = 48'h004136080000;
                7'd92: r = 48'h00007f000000;
                7'd93: r = 48'h000836410000;
                7'd94: r = 48'h081008081000;
                7'd95: r = 48'h784641467800;
                default: r = 48'h000000000000;
            endcase
            font_row = r;
        end
    endfunction

endpackage

>>> rtl/tfb_digit_unit.sv
`timescale 1ns / 1ps
// Subtract/compare unit: produces decimal digits most significant first
// by repeated subtraction of a power of ten, one subtraction per cycle while no digit waits for digit_ack.
module tfb_digit_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] value,
    input  logic        digit_ack,
    output logic        digit_valid,
    output logic [3:0]  digit,
    output logic        done
);

    logic [15:0] rem_reg, rem_next;
    logic [2:0]  pos_reg, pos_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        seen_reg, seen_next;
    logic        hold_reg, hold_next;
    logic [15:0] pow;
    logic [16:0] diff;

    always_comb
    begin
        case (pos_reg)
            3'd0:    pow = 16'd10000;
            3'd1:    pow = 16'd1000;
            3'd2:    pow = 16'd100;
            3'd3:    pow = 16'd10;
            default: pow = 16'd1;
        endcase
    end

    assign diff = {1'b0, rem_reg} - {1'b0, pow};
    assign digit = cnt_reg;
    assign digit_valid = hold_reg;
    // hold done after the last digit until the next start
    assign done = !hold_reg && (pos_reg == 3'd5);

    always_comb
    begin
        rem_next  = rem_reg;
        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        seen_next = seen_reg;
        hold_next = hold_reg;
        if (start)
        begin
            rem_next  = value;
            pos_next  = 3'd0;
            cnt_next  = 4'd0;
            busy_next = 1'b1;
            seen_next = 1'b0;
            hold_next = 1'b0;
        end
        else if (hold_reg)
        begin
            if (digit_ack)
            begin
                hold_next = 1'b0;
                cnt_next  = 4'd0;
                pos_next  = pos_reg + 3'd1;
            end
        end
        else if (busy_reg && pos_reg != 3'd5)
        begin
            if (!diff[16])
            begin
                // subtract one more power of ten
                rem_next = diff[15:0];
                cnt_next = cnt_reg + 4'd1;
            end
            else if (cnt_reg != 4'd0 || seen_reg || pos_reg == 3'd4)
            begin
                hold_next = 1'b1;
                seen_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
            end
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 3'd0;
            cnt_reg  <= 4'd0;
            busy_reg <= 1'b0;
            seen_reg <= 1'b0;
            hold_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            seen_reg <= seen_next;
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

endmodule

>>> rtl/tfb_store.sv
`timescale 1ns / 1ps
// Frame store memory, one write port and one registered read port.
module tfb_store #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
)
(
    input  logic              clk,
    input  logic [AW-1:0]     wr_addr,
    input  tfb_pkg::wr_req_t  wr,
    input  logic [AW-1:0]     rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            mem[wr_addr] <= wr.wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/text_frame_buffer_with_scanout_unit.sv
`timescale 1ns / 1ps
// Page-mode text frame buffer with panel scan-out. The store holds COLUMNS
// columns by PAGES pages of bytes (eight vertical pixels each), addressed
// column*PAGES+page. After reset a clearing pass writes zeros to every entry,
// one per cycle, while s_tready is low. Item handling, set by the single
// store write port and the digit unit: a glyph writes its columns in turn,
// a clear writes zeros to every entry, a number is drawn digit by digit
// (repeated subtraction of a power of ten, one per cycle while no digit
// waits to be drawn), and a refresh byte goes from a store read to the
// result register, held until m_tready takes it. One item is in work at a time.
module text_frame_buffer_with_scanout_unit #(
    parameter int unsigned COLUMNS            = 128,
    parameter int unsigned PAGES              = 8,
    parameter int unsigned CONTROLLER_COLUMNS = 132
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0], column[8:2], row[14:9], char_code[22:15], invert[23], number[39:24]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte[7:0]
    output logic [7:0]  m_tdata,
    // is_data[0]
    output logic        m_tuser,
    output logic        m_tlast
);

    localparam int unsigned DEPTH = COLUMNS * PAGES;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(COLUMNS);
    localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int unsigned SLOTS = tfb_pkg::HEADER_SLOTS + CONTROLLER_COLUMNS;

    tfb_pkg::state_t state_reg, state_next;

    // latched item
    logic [8:0]  col_reg;       // current glyph left column, may run past COLUMNS
    logic [2:0]  page_reg;
    logic [7:0]  code_reg;
    logic        inv_reg;
    logic        num_mode_reg;
    logic [2:0]  gcol_reg;      // column within glyph
    logic [AW:0] clr_reg;       // clearing address
    logic        init_reg;      // clearing pass after reset
    logic [3:0]  scan_page_reg;
    logic [8:0]  scan_slot_reg;
    logic        hdr_reg;
    logic [7:0]  hdr_byte_reg;
    logic        data_zero_reg;
    logic        fend_reg;
    logic        out_valid_reg;
    logic        out_data_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    logic        accept;
    logic [1:0]  in_cmd;
    logic [47:0] glyph;
    logic [7:0]  gbyte;
    logic        in_font;
    logic [8:0]  wcol;
    tfb_pkg::wr_req_t wr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]  rd_data;
    logic        dg_start, dg_valid, dg_done;
    logic [3:0]  dg_digit;
    logic        dg_ack;
    logic [8:0]  scan_col;

    assign in_cmd   = s_tdata[1:0];
    assign s_tready = (state_reg == tfb_pkg::ST_IDLE) && !out_valid_reg && !init_reg;
    assign accept   = s_tvalid && s_tready;

    // Glyph byte for the current column of the current glyph.
    assign in_font = (code_reg >= tfb_pkg::FONT_FIRST) && (code_reg <= tfb_pkg::FONT_LAST);
    assign glyph   = in_font ? tfb_pkg::font_row(7'(code_reg - tfb_pkg::FONT_FIRST)) : 48'd0;
    assign gbyte   = glyph[gcol_reg*8 +: 8] ^ {8{inv_reg}};
    assign wcol    = col_reg + 9'(gcol_reg);

    // Write port: clearing pass or glyph column.
    always_comb
    begin
        wr.wr_en   = 1'b0;
        wr.wr_data = 8'd0;
        wr_addr    = clr_reg[AW-1:0];
        if (state_reg == tfb_pkg::ST_CLEAR)
        begin
            wr.wr_en = 1'b1;
        end
        else if (state_reg == tfb_pkg::ST_DRAW)
        begin
            wr.wr_en   = (wcol < 9'(COLUMNS)) && (32'(page_reg) < PAGES);
            wr.wr_data = gbyte;
            wr_addr    = AW'(32'(wcol) * PAGES + 32'(page_reg));
        end
    end

    assign scan_col = 9'(CONTROLLER_COLUMNS - 1 + tfb_pkg::HEADER_SLOTS) - scan_slot_reg;
    assign rd_addr  = AW'(32'(scan_col[CW-1:0]) * PAGES + 32'(scan_page_reg));

    tfb_store #(.DEPTH(DEPTH), .AW(AW)) u_store
    (
        .clk     (clk),
        .wr_addr (wr_addr),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign dg_start = accept && (in_cmd == tfb_pkg::CMD_NUMBER);
    assign dg_ack   = (state_reg == tfb_pkg::ST_DIGIT) && dg_valid;

    tfb_digit_unit u_digit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (dg_start),
        .value       (s_tdata[39:24]),
        .digit_ack   (dg_ack),
        .digit_valid (dg_valid),
        .digit       (dg_digit),
        .done        (dg_done)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tfb_pkg::ST_IDLE:
            begin
                if (init_reg)
                begin
                    state_next = tfb_pkg::ST_CLEAR;
                end
                else if (accept)
                begin
                    case (in_cmd)
                        tfb_pkg::CMD_GLYPH:  state_next = tfb_pkg::ST_DRAW;
                        tfb_pkg::CMD_NUMBER: state_next = tfb_pkg::ST_DIGIT;
                        tfb_pkg::CMD_CLEAR:  state_next = tfb_pkg::ST_CLEAR;
                        default:             state_next = tfb_pkg::ST_READ;
                    endcase
                end
            end
            tfb_pkg::ST_DIGIT:
            begin
                if (dg_valid)
                begin
                    state_next = tfb_pkg::ST_DRAW;
                end
                else if (dg_done)
                begin
                    state_next = tfb_pkg::ST_IDLE;
                end
            end
            tfb_pkg::ST_DRAW:
            begin
                if (gcol_reg == 3'(tfb_pkg::GLYPH_COLS - 1))
                begin
                    state_next = num_mode_reg ? tfb_pkg::ST_DIGIT : tfb_pkg::ST_IDLE;
                end
            end
            tfb_pkg::ST_CLEAR:
            begin
                if (clr_reg == (AW+1)'(DEPTH - 1))
                begin
                    state_next = tfb_pkg::ST_IDLE;
                end
            end
            tfb_pkg::ST_READ: state_next = tfb_pkg::ST_OUT;
            tfb_pkg::ST_OUT:  state_next = tfb_pkg::ST_IDLE;
            default:          state_next = tfb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfb_pkg::ST_IDLE;
            init_reg      <= 1'b1;
            clr_reg       <= '0;
            gcol_reg      <= 3'd0;
            num_mode_reg  <= 1'b0;
            scan_page_reg <= 4'd0;
            scan_slot_reg <= 9'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tfb_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(DEPTH - 1))
                begin
                    init_reg <= 1'b0;
                end
            end
            else
            begin
                clr_reg <= '0;
            end
            if (state_reg == tfb_pkg::ST_DRAW)
            begin
                gcol_reg <= (gcol_reg == 3'(tfb_pkg::GLYPH_COLS - 1)) ? 3'd0 : gcol_reg + 3'd1;
            end
            if (accept)
            begin
                num_mode_reg <= (in_cmd == tfb_pkg::CMD_NUMBER);
            end
            // advance scan position once the byte is read
            if (state_reg == tfb_pkg::ST_READ)
            begin
                if (scan_slot_reg == 9'(SLOTS - 1))
                begin
                    scan_slot_reg <= 9'd0;
                    scan_page_reg <= (scan_page_reg == 4'(PAGES - 1)) ? 4'd0
                                                                      : scan_page_reg + 4'd1;
                end
                else
                begin
                    scan_slot_reg <= scan_slot_reg + 9'd1;
                end
            end
            if (state_reg == tfb_pkg::ST_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg  <= {2'b00, s_tdata[8:2]};
            page_reg <= s_tdata[14:12];
            code_reg <= s_tdata[22:15];
            inv_reg  <= s_tdata[23];
        end
        else if (dg_ack)
        begin
            // each digit starts one glyph width further right
            col_reg  <= col_reg + 9'(tfb_pkg::GLYPH_COLS);
            code_reg <= tfb_pkg::DIGIT_BASE + 8'(dg_digit);
            inv_reg  <= 1'b0;
        end
        if (state_reg == tfb_pkg::ST_READ)
        begin
            hdr_reg       <= scan_slot_reg < 9'(tfb_pkg::HEADER_SLOTS);
            data_zero_reg <= scan_col >= 9'(COLUMNS);
            fend_reg      <= (scan_slot_reg == 9'(SLOTS - 1))
                             && (scan_page_reg == 4'(PAGES - 1));
            case (scan_slot_reg[1:0])
                2'd0:    hdr_byte_reg <= tfb_pkg::PAGE_CMD + 8'(scan_page_reg);
                2'd1:    hdr_byte_reg <= tfb_pkg::COL_LOW_CMD;
                default: hdr_byte_reg <= tfb_pkg::COL_HIGH_CMD;
            endcase
        end
        if (state_reg == tfb_pkg::ST_OUT)
        begin
            out_data_reg <= !hdr_reg;
            out_byte_reg <= hdr_reg ? hdr_byte_reg : (data_zero_reg ? 8'd0 : rd_data);
            out_last_reg <= fend_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // A glyph write never lands outside the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tfb_pkg::ST_DRAW && wr.wr_en) |-> (32'(wr_addr) < DEPTH))
        else $error("glyph write outside store");

    // Nothing is accepted during the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> !s_tready)
        else $error("item accepted during clearing pass");

    // A result appears only after a scan read.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == tfb_pkg::ST_OUT)
        else $error("result without scan command");

endmodule
